// ----- src/jsu_pkg.sv -----
// ----------------------------------------------------------------------------
// jsu_pkg
// Types, result codes and helper functions shared by the JSON string unescaper.
// ----------------------------------------------------------------------------
`default_nettype none

package jsu_pkg;

	localparam logic [1:0] KIND_DATA  = 2'd0;
	localparam logic [1:0] KIND_DONE  = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_text;
	} text_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [1:0] result_kind;
		logic       last_of_run;
	} result_item_t;

	// all results of one input byte: up to four entries, the last one may be done or error
	typedef struct packed {
		logic [2:0]      n;
		logic [1:0]      last_kind;
		logic [3:0][7:0] bytes;
	} jsu_bundle_t;

	typedef struct packed {
		logic [2:0]      n;
		logic [3:0][7:0] b;
	} utf8_t;

	// {valid, value}
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [4:0] r;
		r = '0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, c[3:0]};
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			r = {1'b1, c[3:0] + 4'd9};
		end
		return r;
	endfunction

	function automatic utf8_t utf8_enc(input logic [20:0] cp);
		utf8_t r;
		r = '0;
		if (cp < 21'h80) begin
			r.n    = 3'd1;
			r.b[0] = cp[7:0];
		end else if (cp < 21'h800) begin
			r.n    = 3'd2;
			r.b[0] = {3'b110, cp[10:6]};
			r.b[1] = {2'b10, cp[5:0]};
		end else if (cp < 21'h10000) begin
			r.n    = 3'd3;
			r.b[0] = {4'b1110, cp[15:12]};
			r.b[1] = {2'b10, cp[11:6]};
			r.b[2] = {2'b10, cp[5:0]};
		end else begin
			r.n    = 3'd4;
			r.b[0] = {5'b11110, cp[20:18]};
			r.b[1] = {2'b10, cp[17:12]};
			r.b[2] = {2'b10, cp[11:6]};
			r.b[3] = {2'b10, cp[5:0]};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- src/jsu_decode.sv -----
// ----------------------------------------------------------------------------
// jsu_decode
// Parser state and the per-byte decode into a bundle of results.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_decode (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 step,
	input  wire jsu_pkg::text_item_t  item,
	output logic                      has_result,
	output jsu_pkg::jsu_bundle_t      bundle
);
	import jsu_pkg::*;

	localparam logic [2:0] PH_IDLE        = 3'd0;
	localparam logic [2:0] PH_STR         = 3'd1;
	localparam logic [2:0] PH_ESC         = 3'd2;
	localparam logic [2:0] PH_HEX         = 3'd3;
	localparam logic [2:0] PH_AFTER_HI    = 3'd4;
	localparam logic [2:0] PH_AFTER_HI_BS = 3'd5;
	localparam logic [2:0] PH_HEX2        = 3'd6;

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSL   = 8'h5c;
	localparam logic [7:0] CH_U     = 8'h75;

	logic [2:0]  phase_q, phase_d;
	logic [1:0]  digit_count_q, digit_count_d;
	logic [15:0] hex_acc_q, hex_acc_d;
	logic [9:0]  held_hi_q, held_hi_d;

	logic [7:0]  c;
	logic [4:0]  hv;
	logic [15:0] acc_new;
	logic        esc_ok;
	logic [7:0]  esc_byte;
	logic        en_a, en_b, done, err;
	logic [20:0] cp_a;
	logic [7:0]  byte_b;
	utf8_t       enc;
	logic [2:0]  n_a, n_data;
	logic [3:0][7:0] bytes;
	logic [20:0] flush_cp;
	logic [20:0] pair_cp;

	always_comb begin
		c        = item.text_byte;
		hv       = hex_digit(c);
		acc_new  = {hex_acc_q[11:0], hv[3:0]};
		flush_cp = {5'd0, 6'b110110, held_hi_q};
		pair_cp  = {({1'b0, held_hi_q} + 11'd64), acc_new[9:0]};
		esc_ok   = 1'b1;
		unique case (c)
			8'h22:   esc_byte = 8'h22;
			8'h5c:   esc_byte = 8'h5c;
			8'h2f:   esc_byte = 8'h2f;
			8'h62:   esc_byte = 8'h08;
			8'h66:   esc_byte = 8'h0c;
			8'h6e:   esc_byte = 8'h0a;
			8'h72:   esc_byte = 8'h0d;
			8'h74:   esc_byte = 8'h09;
			default: begin
				esc_byte = 8'h00;
				esc_ok   = 1'b0;
			end
		endcase
	end

	always_comb begin
		phase_d       = phase_q;
		digit_count_d = digit_count_q;
		hex_acc_d     = hex_acc_q;
		held_hi_d     = held_hi_q;
		en_a          = 1'b0;
		cp_a          = flush_cp;
		en_b          = 1'b0;
		byte_b        = c;
		done          = 1'b0;
		err           = 1'b0;
		unique case (phase_q)
			PH_IDLE: begin
				if (c == CH_QUOTE) begin
					phase_d = PH_STR;
				end else begin
					err = 1'b1;
				end
			end
			PH_STR, PH_AFTER_HI: begin
				if (phase_q == PH_AFTER_HI && c == CH_BSL) begin
					phase_d = PH_AFTER_HI_BS;
				end else begin
					en_a    = (phase_q == PH_AFTER_HI);
					phase_d = PH_STR;
					if (c == CH_QUOTE) begin
						done    = 1'b1;
						phase_d = PH_IDLE;
					end else if (c == CH_BSL) begin
						phase_d = PH_ESC;
					end else begin
						en_b = 1'b1;
					end
				end
			end
			PH_ESC, PH_AFTER_HI_BS: begin
				if (c == CH_U) begin
					phase_d       = (phase_q == PH_ESC) ? PH_HEX : PH_HEX2;
					digit_count_d = 2'd0;
					hex_acc_d     = '0;
				end else if (esc_ok) begin
					en_a    = (phase_q == PH_AFTER_HI_BS);
					en_b    = 1'b1;
					byte_b  = esc_byte;
					phase_d = PH_STR;
				end else begin
					err = 1'b1;
				end
			end
			PH_HEX, PH_HEX2: begin
				if (!hv[4]) begin
					err = 1'b1;
				end else begin
					hex_acc_d = acc_new;
					if (digit_count_q == 2'd3) begin
						digit_count_d = 2'd0;
						phase_d       = PH_STR;
						if (phase_q == PH_HEX) begin
							if (acc_new >= 16'hd800 && acc_new <= 16'hdbff) begin
								held_hi_d = acc_new[9:0];
								phase_d   = PH_AFTER_HI;
							end else begin
								en_a = 1'b1;
								cp_a = {5'd0, acc_new};
							end
						end else begin
							en_a = 1'b1;
							if (acc_new >= 16'hdc00 && acc_new <= 16'hdfff) begin
								cp_a = pair_cp;
							end
						end
					end else begin
						digit_count_d = digit_count_q + 2'd1;
					end
				end
			end
			default: begin
				err = 1'b1;
			end
		endcase
		if (item.end_of_text && phase_d != PH_IDLE) begin
			err = 1'b1;
		end
		if (done || err) begin
			phase_d       = PH_IDLE;
			digit_count_d = 2'd0;
			hex_acc_d     = '0;
			held_hi_d     = '0;
		end
	end

	always_comb begin
		enc    = utf8_enc(cp_a);
		n_a    = en_a ? enc.n : 3'd0;
		bytes  = en_a ? enc.b : '0;
		if (en_b) begin
			bytes[n_a[1:0]] = byte_b;
		end
		n_data = n_a + {2'd0, en_b};
		bundle = '0;
		if (err) begin
			bundle.n         = 3'd1;
			bundle.last_kind = KIND_ERROR;
		end else begin
			bundle.bytes     = bytes;
			bundle.n         = n_data + {2'd0, done};
			bundle.last_kind = done ? KIND_DONE : KIND_DATA;
		end
		has_result = (bundle.n != 3'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			digit_count_q <= 2'd0;
			hex_acc_q     <= '0;
			held_hi_q     <= '0;
		end else if (step) begin
			phase_q       <= phase_d;
			digit_count_q <= digit_count_d;
			hex_acc_q     <= hex_acc_d;
			held_hi_q     <= held_hi_d;
		end
	end

endmodule

`default_nettype wire

// ----- src/jsu_queue.sv -----
// ----------------------------------------------------------------------------
// jsu_queue
// Two-entry queue of result bundles, unpacked one result per output item.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_queue (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   push,
	input  wire jsu_pkg::jsu_bundle_t   push_data,
	output logic                        push_ok,
	output logic                        result_valid,
	input  wire logic                   result_stall,
	output jsu_pkg::result_item_t       result_item
);
	import jsu_pkg::*;

	jsu_bundle_t ent_q [2];
	logic        wr_ptr_q, rd_ptr_q;
	logic [1:0]  count_q;
	logic [1:0]  idx_q;

	jsu_bundle_t head;
	logic [2:0]  n_m1;
	logic        is_last, take, pop;

	always_comb begin
		head         = ent_q[rd_ptr_q];
		n_m1         = head.n - 3'd1;
		is_last      = (idx_q == n_m1[1:0]);
		result_valid = (count_q != 2'd0);
		take         = result_valid && !result_stall;
		pop          = take && is_last;
		push_ok      = (count_q != 2'd2) || pop;
		result_item.last_of_run = is_last;
		result_item.result_kind = is_last ? head.last_kind : KIND_DATA;
		result_item.out_byte    = (result_item.result_kind == KIND_DATA) ?
			head.bytes[idx_q] : 8'h00;
	end

	always_ff @(posedge clk) begin
		if (push && push_ok) begin
			ent_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
			idx_q    <= 2'd0;
		end else begin
			if (push && push_ok) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
				idx_q    <= 2'd0;
			end else if (take) begin
				idx_q <= idx_q + 2'd1;
			end
			count_q <= count_q + {1'b0, push && push_ok} - {1'b0, pop};
		end
	end

endmodule

`default_nettype wire

// ----- src/json_string_unescape_utf8.sv -----
// ----------------------------------------------------------------------------
// json_string_unescape_utf8
// Unescapes a quoted JSON string, one text byte per item, into UTF-8 bytes.
// ----------------------------------------------------------------------------
//  channel  handshake                  payload
//  text     text_valid / text_stall    text_item   (text_byte, end_of_text)
//  result   result_valid / result_stall result_item (out_byte, result_kind, last_of_run)
//
//  one text item per cycle while text_stall is low; each is registered, then decoded,
//  and its results are registered in the queue; they leave one per cycle unless
//  stalled, and a two-bundle queue absorbs bytes that give three or four results
//  bytes that give no result (opening quote, backslash, hex digits) leave no gap
//  after reset the block expects an opening quote with no result pending
//  a stalled output fills the queue and then raises text_stall
// ----------------------------------------------------------------------------
`default_nettype none

module json_string_unescape_utf8 (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   text_valid,
	output logic                        text_stall,
	input  wire jsu_pkg::text_item_t    text_item,
	output logic                        result_valid,
	input  wire logic                   result_stall,
	output jsu_pkg::result_item_t       result_item
);
	import jsu_pkg::*;

	logic        valid_s1;
	text_item_t  item_s1;
	logic        has_result, push_ok, advance;
	jsu_bundle_t bundle;

	assign advance    = valid_s1 && (!has_result || push_ok);
	assign text_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!text_stall) begin
			valid_s1 <= text_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text_valid && !text_stall) begin
			item_s1 <= text_item;
		end
	end

	jsu_decode u_decode (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.item       (item_s1),
		.has_result (has_result),
		.bundle     (bundle)
	);

	jsu_queue u_queue (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (advance && has_result),
		.push_data    (bundle),
		.push_ok      (push_ok),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_item  (result_item)
	);

endmodule

`default_nettype wire
